// File: design/humidity_reading_parser_median_unit_assert.svh
// Assertion macros shared by the humidity reading parser RTL.
`ifndef HUMIDITY_READING_PARSER_MEDIAN_UNIT_ASSERT_SVH
`define HUMIDITY_READING_PARSER_MEDIAN_UNIT_ASSERT_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define HRPM_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cond never holds.
`define HRPM_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// File: design/hrpm_pkg.sv
// Package: types, character codes and limits for the humidity reading parser.
`timescale 1ns / 1ps
`default_nettype none

package hrpm_pkg;

    localparam int VAL_W           = 14;
    localparam int TIMEOUT_W       = 16;
    localparam int WARMUP_W        = 3;
    localparam int CHAR_W          = 8;
    localparam int FC_W            = 4;
    localparam int INT_W           = 14;
    localparam int FRAC_W          = 7;
    localparam int FDIG_W          = 2;
    localparam int TOTAL_W         = 21;
    localparam int DIGIT_SUM_W     = 18;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 16;
    localparam int MAX_FIELD_CHARS = 10;
    localparam int MED_TAPS        = 5;
    localparam int HIST_DEPTH      = 4;
    localparam int RANK_W          = 3;

    localparam logic [VAL_W-1:0]     VAL_MAX        = 14'd16383;
    localparam logic [RANK_W-1:0]    MED_RANK       = 3'd2;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_SAT    = 16'hFFFF;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET  = 16'd5000;
    localparam logic [VAL_W-1:0]     MAX_VAL_RESET  = 14'd10000;
    localparam logic [VAL_W-1:0]     MIN_VAL_RESET  = 14'd0;
    localparam logic [WARMUP_W-1:0]  WARMUP_RESET   = 3'd5;

    localparam logic ACTION_BYTE = 1'b0;
    localparam logic ACTION_TICK = 1'b1;

    localparam logic [CHAR_W-1:0] CH_R     = 8'h52;
    localparam logic [CHAR_W-1:0] CH_H     = 8'h48;
    localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_PCT   = 8'h25;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

    typedef enum logic [1:0] {
        PFX_R,
        PFX_H,
        PFX_EQ,
        PFX_FIELD
    } prefix_stage_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT,
        CFG_MAX_VALUE,
        CFG_MIN_VALUE,
        CFG_WARMUP
    } cfg_index_t;

    typedef struct packed {
        logic             accepted;
        logic             rejected;
        logic [VAL_W-1:0] sample;
    } field_done_t;

endpackage

`default_nettype wire

// File: design/hrpm_ifs.sv
// Interfaces: input beat, result beat and configuration write channels.
`timescale 1ns / 1ps
`default_nettype none

interface hrpm_rx_if;
    import hrpm_pkg::*;
    logic              valid;
    logic              ready;
    logic              action;
    logic [CHAR_W-1:0] rx_byte;

    modport source (output valid, output action, output rx_byte, input ready);
    modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

interface hrpm_reading_if;
    import hrpm_pkg::*;
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] filtered_value;
    logic             value_ok;
    logic             new_reading;
    logic             reading_rejected;

    modport source (output valid, output filtered_value, output value_ok,
                    output new_reading, output reading_rejected, input ready);
    modport sink   (input valid, input filtered_value, input value_ok,
                    input new_reading, input reading_rejected, output ready);
endinterface

interface hrpm_cfg_if;
    import hrpm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: design/humidity_reading_parser_median_unit.sv
// Top level: input register, parser, median filter, ok tracking and result register.
//
//  channel   role   beat payload
//  rx        sink   action, rx_byte
//  reading   source filtered_value, value_ok, new_reading, reading_rejected
//  cfg       sink   index, data (always ready)
//
//  One beat per cycle while reading is not stalled; an rx beat passes from the input
//  register through the parse/median logic into the result register.
//  Async active-low reset sets all but the stage data registers to documented values.
//  A stalled reading holds the result register; rx keeps taking one more beat into
//  the input register, then stalls until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

`include "humidity_reading_parser_median_unit_assert.svh"

module humidity_reading_parser_median_unit
    import hrpm_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    hrpm_rx_if.sink         rx,
    hrpm_reading_if.source  reading,
    hrpm_cfg_if.sink        cfg
);

    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [VAL_W-1:0]     max_value_reg;
    logic [VAL_W-1:0]     min_value_reg;
    logic [WARMUP_W-1:0]  warmup_samples_reg;

    logic                 s1_valid_reg, s1_valid_next;
    logic                 s1_action_reg;
    logic [CHAR_W-1:0]    s1_byte_reg;

    logic [VAL_W-1:0]     filtered_reg, filtered_next;
    logic [WARMUP_W-1:0]  warmup_reg, warmup_next;
    logic                 ok_reg, ok_next;
    logic [TIMEOUT_W-1:0] ms_reg, ms_next;

    logic                 out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]     out_value_reg;
    logic                 out_ok_reg;
    logic                 out_new_reg;
    logic                 out_rej_reg;

    logic                 advance;
    logic                 rx_take;
    field_done_t          done;
    logic [VAL_W-1:0]     median;

    assign advance   = s1_valid_reg && (!out_valid_reg || reading.ready);
    assign rx.ready  = !s1_valid_reg || advance;
    assign rx_take   = rx.valid && rx.ready;
    assign cfg.ready = 1'b1;

    assign reading.valid            = out_valid_reg;
    assign reading.filtered_value   = out_value_reg;
    assign reading.value_ok         = out_ok_reg;
    assign reading.new_reading      = out_new_reg;
    assign reading.reading_rejected = out_rej_reg;

    hrpm_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (advance),
        .action    (s1_action_reg),
        .rx_byte   (s1_byte_reg),
        .min_value (min_value_reg),
        .max_value (max_value_reg),
        .done      (done)
    );

    hrpm_median u_median (
        .clk    (clk),
        .rst_n  (rst_n),
        .shift  (done.accepted),
        .sample (done.sample),
        .median (median)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg        <= TIMEOUT_RESET;
            max_value_reg      <= MAX_VAL_RESET;
            min_value_reg      <= MIN_VAL_RESET;
            warmup_samples_reg <= WARMUP_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg_index_t'(cfg.index))
                CFG_TIMEOUT:   timeout_reg        <= cfg.data;
                CFG_MAX_VALUE: max_value_reg      <= cfg.data[VAL_W-1:0];
                CFG_MIN_VALUE: min_value_reg      <= cfg.data[VAL_W-1:0];
                CFG_WARMUP:    warmup_samples_reg <= cfg.data[WARMUP_W-1:0];
                default:       timeout_reg        <= timeout_reg;
            endcase
        end
    end

    always_comb
    begin
        s1_valid_next = rx_take ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
        out_valid_next = advance ? 1'b1 : (reading.ready ? 1'b0 : out_valid_reg);

        ms_next       = ms_reg;
        filtered_next = filtered_reg;
        warmup_next   = warmup_reg;
        ok_next       = ok_reg;

        if (advance)
        begin
            if ((s1_action_reg == ACTION_TICK) && (ms_reg != TIMEOUT_SAT))
                ms_next = ms_reg + TIMEOUT_W'(1);
            if (done.accepted)
            begin
                ms_next       = '0;
                filtered_next = median;
                if (warmup_reg < warmup_samples_reg)
                    warmup_next = warmup_reg + WARMUP_W'(1);
                else
                    ok_next = 1'b1;
            end
            // drop ok and restart warmup once the reading goes stale
            if (ms_next > timeout_reg)
            begin
                ok_next     = 1'b0;
                warmup_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            filtered_reg  <= '0;
            warmup_reg    <= '0;
            ok_reg        <= 1'b0;
            ms_reg        <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            filtered_reg  <= filtered_next;
            warmup_reg    <= warmup_next;
            ok_reg        <= ok_next;
            ms_reg        <= ms_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_take)
        begin
            s1_action_reg <= rx.action;
            s1_byte_reg   <= rx.rx_byte;
        end
        if (advance)
        begin
            out_value_reg <= filtered_next;
            out_ok_reg    <= ok_next;
            out_new_reg   <= done.accepted;
            out_rej_reg   <= done.rejected;
        end
    end

    `HRPM_ASSERT_NEVER(a_flags_excl, out_valid_reg && out_new_reg && out_rej_reg, "both flags")
    `HRPM_ASSERT_IMPLIES(a_new_ms, out_valid_reg && out_new_reg, ms_reg == '0, "ms not cleared")
    `HRPM_ASSERT_IMPLIES(a_value, out_valid_reg, out_value_reg == filtered_reg, "value mismatch")
    `HRPM_ASSERT_IMPLIES(a_ok_tracks, out_valid_reg, out_ok_reg == ok_reg, "ok mismatch")

endmodule

`default_nettype wire

// File: design/hrpm_parser.sv
// Parser: prefix search, per-character number parse and field completion.
`timescale 1ns / 1ps
`default_nettype none

module hrpm_parser
    import hrpm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              enable,
    input  logic              action,
    input  logic [CHAR_W-1:0] rx_byte,
    input  logic [VAL_W-1:0]  min_value,
    input  logic [VAL_W-1:0]  max_value,
    output field_done_t       done
);

    prefix_stage_t     stage_reg, stage_next;
    logic [FC_W-1:0]   chars_reg, chars_next;
    logic [INT_W-1:0]  int_reg, int_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;
    logic [FDIG_W-1:0] fdig_reg, fdig_next;
    logic              sign_reg, sign_next;
    logic              point_reg, point_next;
    logic              started_reg, started_next;
    logic              stopped_reg, stopped_next;
    logic              over_reg, over_next;

    logic                   is_digit;
    logic                   is_space;
    logic [3:0]             digit;
    logic [DIGIT_SUM_W-1:0] int_digit;
    logic [FRAC_W-1:0]      frac_scaled;
    logic [TOTAL_W-1:0]     total;
    logic                   total_over;
    logic [VAL_W-1:0]       sample;
    logic                   negative;
    logic                   bad;

    assign is_digit  = (rx_byte >= CH_0) && (rx_byte <= CH_9);
    assign is_space  = (rx_byte == CH_SPACE) || ((rx_byte >= CH_TAB) && (rx_byte <= CH_CR));
    assign digit     = rx_byte[3:0];
    assign int_digit = DIGIT_SUM_W'(int_reg) * DIGIT_SUM_W'(10) + DIGIT_SUM_W'(digit);

    always_comb
    begin
        case (fdig_reg)
            2'd0:    frac_scaled = '0;
            2'd1:    frac_scaled = FRAC_W'(frac_reg * FRAC_W'(10));
            default: frac_scaled = frac_reg;
        endcase
    end

    assign total      = TOTAL_W'(int_reg) * TOTAL_W'(100) + TOTAL_W'(frac_scaled);
    assign total_over = total > TOTAL_W'(VAL_MAX);
    assign sample     = total_over ? VAL_MAX : total[VAL_W-1:0];
    assign negative   = sign_reg && (total != '0);
    assign bad        = over_reg || total_over || negative
                        || (sample < min_value) || (sample > max_value);

    always_comb
    begin
        stage_next   = stage_reg;
        chars_next   = chars_reg;
        int_next     = int_reg;
        frac_next    = frac_reg;
        fdig_next    = fdig_reg;
        sign_next    = sign_reg;
        point_next   = point_reg;
        started_next = started_reg;
        stopped_next = stopped_reg;
        over_next    = over_reg;
        done.accepted = 1'b0;
        done.rejected = 1'b0;
        done.sample   = sample;

        if (enable && (action == ACTION_BYTE))
        begin
            case (stage_reg)
                PFX_R:
                begin
                    if (rx_byte == CH_R)
                        stage_next = PFX_H;
                end
                PFX_H:
                begin
                    stage_next = (rx_byte == CH_H) ? PFX_EQ : PFX_R;
                end
                PFX_EQ:
                begin
                    stage_next = (rx_byte == CH_EQ) ? PFX_FIELD : PFX_R;
                end
                PFX_FIELD:
                begin
                    if (rx_byte == CH_PCT)
                    begin
                        done.accepted = !bad;
                        done.rejected = bad;
                        stage_next   = PFX_R;
                        chars_next   = '0;
                        int_next     = '0;
                        frac_next    = '0;
                        fdig_next    = '0;
                        sign_next    = 1'b0;
                        point_next   = 1'b0;
                        started_next = 1'b0;
                        stopped_next = 1'b0;
                        over_next    = 1'b0;
                    end
                    else
                    begin
                        if (!stopped_reg && (started_reg || !is_space))
                        begin
                            if (!started_reg && ((rx_byte == CH_PLUS) || (rx_byte == CH_MINUS)))
                            begin
                                started_next = 1'b1;
                                sign_next    = (rx_byte == CH_MINUS);
                            end
                            else
                            begin
                                started_next = 1'b1;
                                if (is_digit)
                                begin
                                    if (!point_reg)
                                    begin
                                        if (over_reg || (int_digit > DIGIT_SUM_W'(VAL_MAX)))
                                        begin
                                            over_next = 1'b1;
                                            int_next  = VAL_MAX;
                                        end
                                        else
                                        begin
                                            int_next = int_digit[INT_W-1:0];
                                        end
                                    end
                                    else if (fdig_reg < 2'd2)
                                    begin
                                        frac_next = FRAC_W'(frac_reg * FRAC_W'(10))
                                                    + FRAC_W'(digit);
                                        fdig_next = fdig_reg + 2'd1;
                                    end
                                end
                                else if ((rx_byte == CH_POINT) && !point_reg)
                                begin
                                    point_next = 1'b1;
                                end
                                else
                                begin
                                    stopped_next = 1'b1;
                                end
                            end
                        end
                        chars_next = chars_reg + FC_W'(1);
                        // drop a field that runs too long and hunt for the prefix again
                        if (chars_next >= FC_W'(MAX_FIELD_CHARS))
                        begin
                            stage_next   = PFX_R;
                            chars_next   = '0;
                            int_next     = '0;
                            frac_next    = '0;
                            fdig_next    = '0;
                            sign_next    = 1'b0;
                            point_next   = 1'b0;
                            started_next = 1'b0;
                            stopped_next = 1'b0;
                            over_next    = 1'b0;
                        end
                    end
                end
                default:
                begin
                    stage_next = PFX_R;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg   <= PFX_R;
            chars_reg   <= '0;
            int_reg     <= '0;
            frac_reg    <= '0;
            fdig_reg    <= '0;
            sign_reg    <= 1'b0;
            point_reg   <= 1'b0;
            started_reg <= 1'b0;
            stopped_reg <= 1'b0;
            over_reg    <= 1'b0;
        end
        else
        begin
            stage_reg   <= stage_next;
            chars_reg   <= chars_next;
            int_reg     <= int_next;
            frac_reg    <= frac_next;
            fdig_reg    <= fdig_next;
            sign_reg    <= sign_next;
            point_reg   <= point_next;
            started_reg <= started_next;
            stopped_reg <= stopped_next;
            over_reg    <= over_next;
        end
    end

endmodule

`default_nettype wire

// File: design/hrpm_median.sv
// Five-sample median: four-entry history and a rank-select network.
`timescale 1ns / 1ps
`default_nettype none

module hrpm_median
    import hrpm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift,
    input  logic [VAL_W-1:0] sample,
    output logic [VAL_W-1:0] median
);

    logic [VAL_W-1:0]  hist_reg [HIST_DEPTH];
    logic [VAL_W-1:0]  w        [MED_TAPS];
    logic [RANK_W-1:0] rank     [MED_TAPS];

    always_comb
    begin
        w[0] = sample;
        for (int i = 0; i < HIST_DEPTH; i++)
            w[i+1] = hist_reg[i];
    end

    always_comb
    begin
        for (int i = 0; i < MED_TAPS; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < MED_TAPS; j++)
            begin
                if ((j != i) && ((w[j] < w[i]) || ((w[j] == w[i]) && (j < i))))
                    rank[i] = rank[i] + RANK_W'(1);
            end
        end
    end

    always_comb
    begin
        median = w[0];
        for (int i = 0; i < MED_TAPS; i++)
        begin
            if (rank[i] == MED_RANK)
                median = w[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HIST_DEPTH; i++)
                hist_reg[i] <= '0;
        end
        else if (shift)
        begin
            hist_reg[0] <= sample;
            for (int i = 1; i < HIST_DEPTH; i++)
                hist_reg[i] <= hist_reg[i-1];
        end
    end

endmodule

`default_nettype wire
